>>> design/twtm_pkg.sv
// shared types and constants of the time window table matcher
package twtm_pkg;

    localparam int unsigned TIME_W  = 17;
    localparam int unsigned INDEX_W = 3;

    localparam logic [TIME_W-1:0] DAY_SECONDS = 17'd86400;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic               op;
        logic [INDEX_W-1:0] entry_index;
        logic [TIME_W-1:0]  window_start;
        logic [TIME_W-1:0]  window_end;
        logic [TIME_W-1:0]  now_seconds;
    } t_req;

    typedef struct packed {
        logic               write_accepted;
        logic               active_found;
        logic [INDEX_W-1:0] active_index;
        logic               next_found;
        logic [INDEX_W-1:0] next_index;
        logic [TIME_W-1:0]  next_wait;
    } t_rsp;

endpackage

>>> design/time_window_table_matcher_core.sv
// time window table matcher: window table in a synchronous memory, query scan sequencer
// write request: table updated at the accepting edge, result strobe in the next cycle
// query request: the scan reads one entry per cycle from the single memory read port,
//   then passes the stage 1, stage 2 and result registers; busy until the result strobe,
//   so no new request is taken before the query's result
// reset (synchronous, active low) clears the sequencer and all valid marks; the
//   window memory is not cleared, its entries are only used behind a valid mark
// the receiver cannot stall: each result is shown for exactly one cycle
module time_window_table_matcher_core
    import twtm_pkg::*;
#(
    parameter int unsigned ENTRIES = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_req i_req,
    output logic o_valid,
    output t_rsp o_rsp
);

    localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned MEM_W = 2 * TIME_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    // sequencer codes
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_READ  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    // window memory: {start, end} per entry, one write and one read port
    logic [MEM_W-1:0] r_mem [ENTRIES];
    logic [ENTRIES-1:0] r_valid;

    logic [1:0]        r_state;
    logic [IDX_W-1:0]  r_rd_idx;
    logic [TIME_W-1:0] r_now;
    logic [TIME_W-1:0] r_now_mod;

    // stage 1: memory read data with its index and valid mark
    logic [MEM_W-1:0]  r_mem_q;
    logic              r_s1_vld;
    logic              r_s1_last;
    logic              r_s1_mark;
    logic [IDX_W-1:0]  r_s1_idx;

    // stage 2: window hit and wait of one entry
    logic              r_s2_vld;
    logic              r_s2_last;
    logic              r_s2_mark;
    logic              r_s2_hit;
    logic [IDX_W-1:0]  r_s2_idx;
    logic [TIME_W-1:0] r_s2_wait;

    // running results of the scan
    logic              r_act;
    logic [IDX_W-1:0]  r_act_idx;
    logic              r_nxt;
    logic [IDX_W-1:0]  r_nxt_idx;
    logic [TIME_W-1:0] r_best;
    logic              n_act;
    logic [IDX_W-1:0]  n_act_idx;
    logic              n_nxt;
    logic [IDX_W-1:0]  n_nxt_idx;
    logic [TIME_W-1:0] n_best;

    logic              accept;
    logic              wr_req;
    logic              qry_req;
    logic              wr_in_range;
    logic              wr_ok;
    logic [IDX_W-1:0]  wr_addr;
    logic [TIME_W-1:0] s1_start;
    logic [TIME_W-1:0] s1_end;
    logic              s1_hit;
    logic [TIME_W:0]   s1_wait;
    logic [TIME_W-1:0] now_mod;

    assign busy    = (r_state != ST_IDLE);
    assign accept  = start && !busy;
    assign wr_req  = accept && (i_req.op == OP_WRITE);
    assign qry_req = accept && (i_req.op == OP_QUERY);

    // writes beyond the table are dropped and reported as not accepted
    assign wr_in_range = (32'(i_req.entry_index) < ENTRIES);
    assign wr_addr     = IDX_W'(i_req.entry_index);
    assign wr_ok       = (i_req.window_start != i_req.window_end)
                      && (i_req.window_start < DAY_SECONDS)
                      && (i_req.window_end < DAY_SECONDS);

    // now below two days, so one conditional subtract reduces it into the day
    assign now_mod = (i_req.now_seconds >= DAY_SECONDS)
                   ? i_req.now_seconds - DAY_SECONDS : i_req.now_seconds;

    // memory write port
    always_ff @(posedge i_clk) begin
        if (wr_req && wr_in_range) begin
            r_mem[wr_addr] <= {i_req.window_start, i_req.window_end};
        end
    end

    // memory read port, one entry per cycle while scanning
    always_ff @(posedge i_clk) begin
        if (r_state == ST_READ) begin
            r_mem_q <= r_mem[r_rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (wr_req && wr_in_range) begin
            r_valid[wr_addr] <= wr_ok;
        end
    end

    // scan sequencer; busy keeps writes off the memory during a scan
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_rd_idx <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (qry_req) begin
                        r_state  <= ST_READ;
                        r_rd_idx <= '0;
                    end
                end
                ST_READ: begin
                    if (r_rd_idx == LAST_IDX) begin
                        r_state <= ST_DRAIN;
                    end else begin
                        r_rd_idx <= r_rd_idx + 1'b1;
                    end
                end
                ST_DRAIN: begin
                    if (r_s2_vld && r_s2_last) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (qry_req) begin
            r_now     <= i_req.now_seconds;
            r_now_mod <= now_mod;
        end
    end

    // stage 1 control travels beside the read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= (r_state == ST_READ);
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_last <= (r_rd_idx == LAST_IDX);
        r_s1_mark <= r_valid[r_rd_idx];
        r_s1_idx  <= r_rd_idx;
    end

    // containment test and wrapped wait of the entry just read
    assign s1_start = r_mem_q[MEM_W-1:TIME_W];
    assign s1_end   = r_mem_q[TIME_W-1:0];
    assign s1_hit   = (s1_start <= r_now) && (r_now <= s1_end);
    assign s1_wait  = (s1_start >= r_now_mod)
                    ? {1'b0, s1_start} - {1'b0, r_now_mod}
                    : {1'b0, s1_start} + {1'b0, DAY_SECONDS} - {1'b0, r_now_mod};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_last <= r_s1_last;
        r_s2_mark <= r_s1_mark;
        r_s2_hit  <= s1_hit;
        r_s2_idx  <= r_s1_idx;
        r_s2_wait <= s1_wait[TIME_W-1:0];
    end

    // first containing window, soonest start with the lower index on ties
    always_comb begin
        n_act     = r_act;
        n_act_idx = r_act_idx;
        n_nxt     = r_nxt;
        n_nxt_idx = r_nxt_idx;
        n_best    = r_best;
        if (r_s2_vld && r_s2_mark) begin
            if (!r_act && r_s2_hit) begin
                n_act     = 1'b1;
                n_act_idx = r_s2_idx;
            end
            if (!r_nxt || (r_s2_wait < r_best)) begin
                n_nxt     = 1'b1;
                n_nxt_idx = r_s2_idx;
                n_best    = r_s2_wait;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (qry_req) begin
            r_act     <= 1'b0;
            r_act_idx <= '0;
            r_nxt     <= 1'b0;
            r_nxt_idx <= '0;
            r_best    <= '0;
        end else begin
            r_act     <= n_act;
            r_act_idx <= n_act_idx;
            r_nxt     <= n_nxt;
            r_nxt_idx <= n_nxt_idx;
            r_best    <= n_best;
        end
    end

    // result register: write results next cycle, query results after the last entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= wr_req || (r_s2_vld && r_s2_last);
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_req) begin
            o_rsp.write_accepted <= wr_in_range && wr_ok;
            o_rsp.active_found   <= 1'b0;
            o_rsp.active_index   <= '0;
            o_rsp.next_found     <= 1'b0;
            o_rsp.next_index     <= '0;
            o_rsp.next_wait      <= '0;
        end else begin
            o_rsp.write_accepted <= 1'b0;
            o_rsp.active_found   <= n_act;
            o_rsp.active_index   <= INDEX_W'(n_act_idx);
            o_rsp.next_found     <= n_nxt;
            o_rsp.next_index     <= INDEX_W'(n_nxt_idx);
            o_rsp.next_wait      <= n_best;
        end
    end

    // a query request always puts the block into its scan
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        qry_req |=> busy)
        else $error("query request did not start a scan");

    // the last scanned entry always yields a result strobe
    a_last_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_vld && r_s2_last) |=> o_valid)
        else $error("scan ended without a result");

    // no read data in flight while the sequencer is idle
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && $past(r_state) == ST_IDLE) |-> !r_s1_vld)
        else $error("read pipeline active while idle");

endmodule

>>> dv/time_window_table_matcher_core_tb.sv
// self-checking testbench of the time window table matcher core
module time_window_table_matcher_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import twtm_pkg::*;

    localparam int unsigned TABLE_DEPTH    = 8;
    localparam int unsigned RAND_ITEMS     = 650;
    // the last stretch of the random part runs back to back
    localparam int unsigned QUIET_TAIL     = 100;
    // a query holds busy for its whole table scan, the sender adds short
    // bursts on top; this leaves a wide margin over the slowest correct case
    localparam int unsigned WATCHDOG_LIMIT = 500;
    localparam int unsigned DRAIN_CYCLES   = TABLE_DEPTH + 8;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    logic o_valid;
    t_req i_req;
    t_rsp o_rsp;

    // directed stimulus: literal expectation where it is obvious, else the predictor
    typedef struct {
        t_req req;
        bit   lit;
        t_rsp rsp;
    } t_plan_row;

    // own copy of the window table, updated as requests are accepted
    logic [TIME_W-1:0] win_start [TABLE_DEPTH];
    logic [TIME_W-1:0] win_end   [TABLE_DEPTH];
    bit                win_live  [TABLE_DEPTH];

    t_rsp        pending_rsp [$];
    t_rsp        rsp_want;
    t_plan_row   plan [$];
    int unsigned err_count;
    int unsigned idle_cycles;
    int unsigned n_writes, n_kept, n_queries, n_active, n_next;

    time_window_table_matcher_core #(
        .ENTRIES(TABLE_DEPTH)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .busy   (busy),
        .i_req  (i_req),
        .o_valid(o_valid),
        .o_rsp  (o_rsp)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // expected result of one request; a write also updates the table copy
    function automatic t_rsp predict_rsp(input t_req r);
        t_rsp        res;
        int unsigned now_s;
        int unsigned day;
        int unsigned gap;
        int unsigned best;
        bit          act;
        bit          nxt;
        res  = '0;
        act  = 1'b0;
        nxt  = 1'b0;
        best = 0;
        day  = 32'(DAY_SECONDS);
        if (r.op == OP_WRITE) begin
            win_start[r.entry_index] = r.window_start;
            win_end[r.entry_index]   = r.window_end;
            // free unless a nonempty window with both ends inside the day
            win_live[r.entry_index]  = (r.window_start != r.window_end) &&
                                       (r.window_start < DAY_SECONDS) &&
                                       (r.window_end < DAY_SECONDS);
            res.write_accepted = win_live[r.entry_index];
            return res;
        end
        now_s = 32'(r.now_seconds);
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (!win_live[i]) continue;
            // crossing-midnight windows have end < start and can never hold now
            if (!act && win_start[i] <= r.now_seconds && r.now_seconds <= win_end[i]) begin
                act = 1'b1;
                res.active_index = INDEX_W'(i);
            end
            // now may be past the day; two days of offset keep the sum positive
            gap = (int'(win_start[i]) + 2 * day - now_s) % day;
            // strict compare: the lower index keeps a tie
            if (!nxt || gap < best) begin
                nxt = 1'b1;
                res.next_index = INDEX_W'(i);
                best = gap;
            end
        end
        res.active_found = act;
        res.next_found   = nxt;
        res.next_wait    = best[TIME_W-1:0];
        return res;
    endfunction

    // unused fields carry random junk so the block is seen to ignore them
    function automatic t_req wr_req(input logic [INDEX_W-1:0] idx,
                                    input logic [TIME_W-1:0] ws,
                                    input logic [TIME_W-1:0] we);
        t_req r;
        r.op           = OP_WRITE;
        r.entry_index  = idx;
        r.window_start = ws;
        r.window_end   = we;
        r.now_seconds  = TIME_W'($urandom_range(0, 131071));
        return r;
    endfunction

    function automatic t_req qr_req(input logic [TIME_W-1:0] now_s);
        t_req r;
        r.op           = OP_QUERY;
        r.entry_index  = INDEX_W'($urandom_range(0, 7));
        r.window_start = TIME_W'($urandom_range(0, 131071));
        r.window_end   = TIME_W'($urandom_range(0, 131071));
        r.now_seconds  = now_s;
        return r;
    endfunction

    function automatic t_rsp rsp_write(input bit ok);
        t_rsp res;
        res = '0;
        res.write_accepted = ok;
        return res;
    endfunction

    // random write: half short windows, some crossing midnight, some rejected
    function automatic t_req rand_write();
        logic [TIME_W-1:0] ws;
        logic [TIME_W-1:0] we;
        ws = TIME_W'($urandom_range(0, 86399));
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: we = ws + TIME_W'($urandom_range(1, 7200));
            5: we = TIME_W'($urandom_range(0, ws));
            6: we = ws;
            7: begin
                ws = TIME_W'($urandom_range(86400, 131071));
                we = TIME_W'($urandom_range(0, 131071));
            end
            8: we = TIME_W'($urandom_range(86400, 131071));
            default: begin
                ws = TIME_W'($urandom_range(0, 131071));
                we = TIME_W'($urandom_range(0, 131071));
            end
        endcase
        return wr_req(INDEX_W'($urandom_range(0, 7)), ws, we);
    endfunction

    // random query: mostly just around the edges of a live window
    function automatic t_req rand_query();
        int unsigned       k;
        int unsigned       sel;
        logic [TIME_W-1:0] now_s;
        k   = $urandom_range(0, TABLE_DEPTH - 1);
        sel = $urandom_range(0, 9);
        if (sel <= 5 && win_live[k]) begin
            now_s = (sel < 3) ? win_start[k] : win_end[k];
            now_s = now_s + TIME_W'($urandom_range(0, 2)) - TIME_W'(1);
        end else if (sel == 8) begin
            now_s = TIME_W'($urandom_range(86400, 131071));
        end else if (sel == 9) begin
            now_s = TIME_W'($urandom_range(0, 131071));
        end else begin
            now_s = TIME_W'($urandom_range(0, 86399));
        end
        return qr_req(now_s);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        err_count++;
    endtask

    task automatic check_field(input string name, input int unsigned got,
                               input int unsigned want);
        if (got != want)
            report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    // drive one request at the falling edge and hold it until the block takes it
    task automatic send_request(input t_req req, input bit lit, input t_rsp lit_rsp,
                                input bit may_idle);
        t_rsp model_rsp;
        if (may_idle && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        i_req = req;
        start = 1'b1;
        forever begin
            @(posedge i_clk);
            if (!busy) break;
            @(negedge i_clk);
            // drop start for a burst while the block works, so gaps land on
            // any phase of the scan, including the cycle busy falls
            if (may_idle && $urandom_range(0, 7) == 0) begin
                start = 1'b0;
                repeat ($urandom_range(1, 3)) @(negedge i_clk);
                start = 1'b1;
            end
        end
        // accepted at this edge; the result strobe comes in the next cycle at the earliest
        model_rsp = predict_rsp(req);
        pending_rsp.push_back(lit ? lit_rsp : model_rsp);
        if (req.op == OP_WRITE) begin
            n_writes++;
            n_kept += model_rsp.write_accepted;
        end else begin
            n_queries++;
            n_active += model_rsp.active_found;
            n_next   += model_rsp.next_found;
        end
        @(negedge i_clk);
        start = 1'b0;
    endtask

    task automatic wait_for_drain();
        while (pending_rsp.size() != 0) @(negedge i_clk);
    endtask

    // result checker: each strobe is matched against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (pending_rsp.size() == 0) begin
                report_mismatch("result strobe with no request pending");
            end else begin
                rsp_want = pending_rsp.pop_front();
                check_field("write_accepted", o_rsp.write_accepted, rsp_want.write_accepted);
                check_field("active_found", o_rsp.active_found, rsp_want.active_found);
                check_field("active_index", o_rsp.active_index, rsp_want.active_index);
                check_field("next_found", o_rsp.next_found, rsp_want.next_found);
                check_field("next_index", o_rsp.next_index, rsp_want.next_index);
                check_field("next_wait", o_rsp.next_wait, rsp_want.next_wait);
            end
        end
    end

    // watchdog: a run of cycles with neither an accepted request nor a result
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_valid) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("[%0t] watchdog: no progress for %0d cycles", $time, idle_cycles);
                $display("time_window_table_matcher_core_tb: errors");
                $finish;
            end
        end
    end

    initial begin
        bit calm;
        bit may_idle;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_req       = '0;
        err_count   = 0;
        idle_cycles = 0;
        n_writes    = 0;
        n_kept      = 0;
        n_queries   = 0;
        n_active    = 0;
        n_next      = 0;
        calm        = 1'b0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            win_start[i] = '0;
            win_end[i]   = '0;
            win_live[i]  = 1'b0;
        end
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // empty table right after reset, at both ends of the now range
        plan.push_back('{qr_req(17'd0), 1'b1, '0});
        plan.push_back('{qr_req(17'd131071), 1'b1, '0});
        // full-day window and the validation corners
        plan.push_back('{wr_req(3'd0, 17'd0, 17'd86399), 1'b1, rsp_write(1'b1)});
        plan.push_back('{wr_req(3'd7, 17'd100, 17'd100), 1'b1, rsp_write(1'b0)});
        plan.push_back('{wr_req(3'd7, 17'd86400, 17'd86401), 1'b1, rsp_write(1'b0)});
        plan.push_back('{wr_req(3'd6, 17'd5, 17'd131071), 1'b1, rsp_write(1'b0)});
        plan.push_back('{wr_req(3'd5, 17'd131071, 17'd0), 1'b1, rsp_write(1'b0)});
        // window crossing midnight: kept, but never active
        plan.push_back('{wr_req(3'd7, 17'd86399, 17'd0), 1'b1, rsp_write(1'b1)});
        plan.push_back('{qr_req(17'd0), 1'b0, '0});
        plan.push_back('{qr_req(17'd86399), 1'b0, '0});
        // now past the end of the day
        plan.push_back('{qr_req(17'd86400), 1'b0, '0});
        plan.push_back('{qr_req(17'd131071), 1'b0, '0});
        // overlapping windows with the same start: lower index wins both lookups
        plan.push_back('{wr_req(3'd3, 17'd1000, 17'd1500), 1'b1, rsp_write(1'b1)});
        plan.push_back('{wr_req(3'd0, 17'd1000, 17'd2000), 1'b1, rsp_write(1'b1)});
        plan.push_back('{qr_req(17'd1000), 1'b0, '0});
        plan.push_back('{qr_req(17'd1501), 1'b0, '0});
        plan.push_back('{qr_req(17'd2001), 1'b0, '0});
        // freeing a live entry by rewriting it with an empty window
        plan.push_back('{wr_req(3'd0, 17'd0, 17'd0), 1'b1, rsp_write(1'b0)});
        plan.push_back('{qr_req(17'd1200), 1'b0, '0});
        plan.push_back('{wr_req(3'd4, 17'd86398, 17'd86399), 1'b1, rsp_write(1'b1)});
        plan.push_back('{qr_req(17'd86399), 1'b0, '0});
        plan.push_back('{qr_req(17'd999), 1'b0, '0});

        foreach (plan[i])
            send_request(plan[i].req, plan[i].lit, plan[i].rsp, 1'b1);

        // hold off until the directed part has fully drained
        wait_for_drain();

        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n % 60 == 0) calm = ($urandom_range(0, 2) == 0);
            may_idle = !calm && (n < RAND_ITEMS - QUIET_TAIL);
            if (n % 100 == 50) wait_for_drain();
            if ($urandom_range(0, 9) < 4) begin
                send_request(rand_write(), 1'b0, '0, may_idle);
            end else begin
                send_request(rand_query(), 1'b0, '0, may_idle);
            end
        end

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d table writes (%0d kept valid) and %0d lookups",
                 n_writes, n_kept, n_queries);
        $display("lookups inside a window: %0d, with an upcoming window: %0d",
                 n_active, n_next);
        if (err_count == 0) begin
            $display("time_window_table_matcher_core_tb: clean");
        end else begin
            $display("time_window_table_matcher_core_tb: errors");
        end
        $finish;
    end

endmodule
